// ===== rtl/core/pte_pkg.sv =====
// Shared types, codes and constants of the page table engine.
package pte_pkg;

	// Default number of 4 KiB table frames held in the table memory.
	localparam int unsigned TABLE_FRAMES_DEF = 64;
	localparam int unsigned ENTRIES   = 512;
	localparam int unsigned IDX_W     = 9;
	localparam int unsigned OFS_W     = 12;
	localparam int unsigned VA_W      = 48;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned LVL_W     = 2;

	typedef enum logic [1:0] {
		OP_MAP    = 2'd0,
		OP_UNMAP  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_BAD    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_DONE    = 2'd0,
		STS_ABSENT  = 2'd1,
		STS_NOFRAME = 2'd2
	} status_t;

	localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    idle;
		logic    link;
		logic    follow;
		logic    clr;
		logic    root;
		logic    leaf_wr;
		logic    set_st;
		status_t st;
		logic    xlat_ld;
		logic    fin;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic lvl_leaf;
		logic present;
		logic link_ok;
		logic full;
		logic sweep_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/pte_req_if.sv =====
// Request channel: one word per operation.
interface pte_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [pte_pkg::VA_W-1:0]      virtual_address;
	logic [pte_pkg::DATA_W-1:0]    physical_address;
	logic [pte_pkg::DATA_W-1:0]    entry_flags;

	modport source (output valid, op, virtual_address, physical_address, entry_flags,
		input ready);
	modport sink (input valid, op, virtual_address, physical_address, entry_flags,
		output ready);
endinterface

// ===== rtl/core/pte_rsp_if.sv =====
// Response channel: one word per completed operation.
interface pte_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [pte_pkg::DATA_W-1:0] translated_address;
	logic [1:0]                 status;

	modport source (output valid, translated_address, status, input ready);
	modport sink (input valid, translated_address, status, output ready);
endinterface

// ===== rtl/core/pte_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pte_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/pte_dp.sv =====
// Datapath of the page table engine: item registers, allocator, table memory, result word.
module pte_dp #(
	parameter int unsigned TABLE_FRAMES = pte_pkg::TABLE_FRAMES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pte_req_if.sink       req,
	pte_rsp_if.source     rsp,
	input  pte_pkg::cmd_t cmd,
	output pte_pkg::sts_t sts
);
	import pte_pkg::*;

	localparam int unsigned FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
	localparam int unsigned UW    = $clog2(TABLE_FRAMES + 1);
	localparam int unsigned AW    = FW + IDX_W;
	localparam int unsigned DEPTH = TABLE_FRAMES * ENTRIES;
	localparam int unsigned NW    = DATA_W - OFS_W;

	op_t               op_q;
	logic [VA_W-1:0]   va_q;
	logic [DATA_W-1:0] pa_q;
	logic [DATA_W-1:0] fl_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [FW-1:0]     fr_q;
	logic [UW-1:0]     used_q;
	logic [IDX_W-1:0]  sweep_q;
	status_t           res_st_q;
	logic [DATA_W-1:0] xlat_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_xlat_q;
	status_t           out_st_q;

	logic              accept;
	logic [IDX_W-1:0]  idx;
	logic [DATA_W-1:0] rdata;
	logic [NW-1:0]     next_fr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] link_val;
	logic [DATA_W-1:0] leaf_val;

	assign accept    = cmd.idle & req.valid;
	assign req.ready = cmd.idle;

	// Index of the current level.
	always_comb begin
		unique case (lvl_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			2'd2:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	assign next_fr  = rdata[DATA_W-1:OFS_W];
	assign link_val = (DATA_W'(used_q) << OFS_W) | DATA_W'(3) | fl_q;
	assign leaf_val = {pa_q[DATA_W-1:OFS_W], {OFS_W{1'b0}}} | DATA_W'(1) | fl_q;

	// Table memory write port: frame clearing, links and leaves.
	always_comb begin
		we    = cmd.clr | cmd.link | cmd.leaf_wr;
		waddr = cmd.clr ? {(cmd.root ? {FW{1'b0}} : fr_q), sweep_q} : {fr_q, idx};
		if (cmd.link) begin
			wdata = link_val;
		end else if (cmd.leaf_wr && op_q == OP_MAP) begin
			wdata = leaf_val;
		end else begin
			wdata = '0;
		end
	end

	pte_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr ({fr_q, idx}),
		.rdata (rdata)
	);

	// Item registers and the walk position.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(req.op);
			va_q <= req.virtual_address;
			pa_q <= req.physical_address;
			fl_q <= req.entry_flags;
		end
		if (accept) begin
			fr_q   <= '0;
			lvl_q  <= '0;
			res_st_q <= STS_DONE;
			xlat_q <= '0;
		end else begin
			if (cmd.link) begin
				fr_q  <= used_q[FW-1:0];
				lvl_q <= lvl_q + 1'b1;
			end else if (cmd.follow) begin
				fr_q  <= next_fr[FW-1:0];
				lvl_q <= lvl_q + 1'b1;
			end
			if (cmd.set_st) begin
				res_st_q <= cmd.st;
			end
			if (cmd.xlat_ld) begin
				xlat_q <= {rdata[DATA_W-1:OFS_W], va_q[OFS_W-1:0]};
			end
		end
	end

	// Frame allocator and clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= UW'(1);
			sweep_q <= '0;
		end else begin
			if (cmd.link) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.clr) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.fin | (out_valid_q & ~rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_xlat_q <= xlat_q;
			out_st_q   <= res_st_q;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.translated_address = out_xlat_q;
	assign rsp.status             = out_st_q;

	// Status towards the controller.
	always_comb begin
		sts.in_valid   = req.valid;
		sts.op         = op_q;
		sts.lvl_leaf   = (lvl_q == LVL_LEAF);
		sts.present    = rdata[0];
		sts.link_ok    = (next_fr < NW'(used_q));
		sts.full       = (used_q >= UW'(TABLE_FRAMES));
		sts.sweep_last = (sweep_q == IDX_W'(ENTRIES - 1));
		sts.out_busy   = out_valid_q & ~rsp.ready;
	end
endmodule

// ===== rtl/core/pte_ctrl.sv =====
// Controller state machine of the page table engine.
module pte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  pte_pkg::sts_t sts,
	output pte_pkg::cmd_t cmd
);
	import pte_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.st  = STS_DONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr  = 1'b1;
				cmd.root = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				priority if (sts.op == OP_BAD) begin
					cmd.set_st = 1'b1;
					cmd.st     = STS_ABSENT;
					state_d    = ST_FINISH;
				end else if (sts.lvl_leaf && sts.op != OP_LOOKUP) begin
					cmd.leaf_wr = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				priority if (sts.lvl_leaf) begin
					if (sts.present) begin
						cmd.xlat_ld = 1'b1;
					end else begin
						cmd.set_st = 1'b1;
						cmd.st     = STS_ABSENT;
					end
					state_d = ST_FINISH;
				end else if (!sts.present && sts.op == OP_MAP && !sts.full) begin
					cmd.link = 1'b1;
					state_d  = ST_CLEAR;
				end else if (!sts.present && sts.op == OP_MAP) begin
					cmd.set_st = 1'b1;
					cmd.st     = STS_NOFRAME;
					state_d    = ST_FINISH;
				end else if (!sts.present || !sts.link_ok) begin
					cmd.set_st = 1'b1;
					cmd.st     = STS_ABSENT;
					state_d    = ST_FINISH;
				end else begin
					cmd.follow = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_READ;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/four_level_page_table_engine.sv =====
// Top level of the four-level page table engine.
//
//  Channel | Direction | Words carried
//  req     | in        | op, virtual_address, physical_address, entry_flags
//  rsp     | out       | translated_address, status
//
// A word enters in ST_IDLE; each table level is read in ST_READ and checked in ST_EVAL,
// and ST_FINISH hands the result on. Map or unmap over an existing path writes the
// leaf in ST_READ of the last level, with no ST_EVAL there.
// Each new table frame is cleared entry by entry through the single memory write port.
// After reset the root frame is cleared entry by entry before req.ready rises.
// The result sits in an output register; a stalled rsp holds only the word after it.
module four_level_page_table_engine #(
	parameter int unsigned TABLE_FRAMES = pte_pkg::TABLE_FRAMES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pte_req_if.sink   req,
	pte_rsp_if.source rsp
);
	import pte_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pte_dp #(.TABLE_FRAMES(TABLE_FRAMES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule
